### hw/rtl/maub_pkg.sv
// Shared types and constants for the Barrett modular arithmetic unit.
// Used by maub_front, maub_barrett and modular_arith_unit_barrett_top; no dependencies.
package maub_pkg;

    typedef enum logic [2:0] {
        REQ_ADD    = 3'd0,
        REQ_SUB    = 3'd1,
        REQ_MUL    = 3'd2,
        REQ_REDUCE = 3'd3,
        REQ_LEE    = 3'd4,
        REQ_SIGNED = 3'd5
    } t_req;

    localparam int REQ_W     = 3;
    localparam int WIDE_W    = 32;
    localparam int RES_W     = 16;
    localparam int MU_W      = 48;
    localparam int MU_HALF_W = MU_W / 2;
    localparam int PP_W      = WIDE_W + MU_HALF_W;
    localparam int SUM_W     = WIDE_W + MU_W;

    typedef struct packed {
        logic              use_barrett;
        logic [WIDE_W-1:0] wide_val;
        logic [RES_W-1:0]  simple_res;
    } t_front;

endpackage

### hw/rtl/maub_front.sv
// Front stage: decodes the request, forms the 16x16 product and the short operations.
// Depends on maub_pkg.
module maub_front #(
    parameter int MODULUS = 65521
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [maub_pkg::REQ_W-1:0]     i_req_type,
    input  logic [maub_pkg::WIDE_W-1:0]    i_operand_a,
    input  logic [maub_pkg::RES_W-1:0]     i_operand_b,
    output logic                           o_valid,
    input  logic                           i_ready,
    output maub_pkg::t_front               o_data
);

    localparam logic [maub_pkg::RES_W-1:0] P16 = maub_pkg::RES_W'(MODULUS);

    logic                        r_valid;
    maub_pkg::t_front            r_data;
    maub_pkg::t_front            n_data;
    logic [maub_pkg::RES_W-1:0]  a16;
    logic [maub_pkg::RES_W:0]    add_sum;
    logic [maub_pkg::RES_W-1:0]  lee_neg;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign a16     = i_operand_a[maub_pkg::RES_W-1:0];
    assign add_sum = {1'b0, a16} + {1'b0, i_operand_b};
    assign lee_neg = P16 - a16;

    always_comb begin
        n_data.use_barrett = 1'b0;
        n_data.wide_val    = i_operand_a;
        n_data.simple_res  = '0;
        case (maub_pkg::t_req'(i_req_type))
            maub_pkg::REQ_ADD: begin
                n_data.simple_res = (add_sum >= {1'b0, P16}) ?
                    maub_pkg::RES_W'(add_sum - {1'b0, P16}) : add_sum[maub_pkg::RES_W-1:0];
            end
            maub_pkg::REQ_SUB: begin
                n_data.simple_res = (a16 >= i_operand_b) ? a16 - i_operand_b
                                                         : a16 - i_operand_b + P16;
            end
            maub_pkg::REQ_MUL: begin
                n_data.use_barrett = 1'b1;
                n_data.wide_val    = a16 * i_operand_b;
            end
            maub_pkg::REQ_REDUCE: begin
                n_data.use_barrett = 1'b1;
            end
            maub_pkg::REQ_LEE: begin
                n_data.simple_res = (lee_neg > a16) ? a16 : lee_neg;
            end
            maub_pkg::REQ_SIGNED: begin
                n_data.simple_res = i_operand_a[maub_pkg::WIDE_W-1] ? a16 + P16 : a16;
            end
            default: begin
                n_data.simple_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

### hw/rtl/maub_barrett.sv
// Four-stage Barrett reduction: split quotient product, quotient, q*P, final correction.
// Depends on maub_pkg.
module maub_barrett #(
    parameter int MODULUS      = 65521,
    parameter int REDUCE_SHIFT = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  maub_pkg::t_front               i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [maub_pkg::RES_W-1:0]     o_residue
);

    localparam logic [63:0] MU64 = (64'd1 << REDUCE_SHIFT) / 64'(MODULUS);
    localparam logic [maub_pkg::MU_HALF_W-1:0] MU_LO = MU64[maub_pkg::MU_HALF_W-1:0];
    localparam logic [maub_pkg::MU_HALF_W-1:0] MU_HI =
        MU64[maub_pkg::MU_W-1:maub_pkg::MU_HALF_W];
    localparam logic [maub_pkg::RES_W-1:0]  P16 = maub_pkg::RES_W'(MODULUS);
    localparam logic [maub_pkg::WIDE_W-1:0] P32 = maub_pkg::WIDE_W'(MODULUS);

    logic                          r_v1, r_v2, r_v3, r_v4;
    logic                          en1, en2, en3, en4;

    maub_pkg::t_front              r_d1, r_d2, r_d3;
    logic [maub_pkg::PP_W-1:0]     r_pp_lo, r_pp_hi;
    logic [maub_pkg::WIDE_W-1:0]   r_quot;
    logic [maub_pkg::WIDE_W-1:0]   r_qp;
    logic [maub_pkg::RES_W-1:0]    r_residue;

    logic [maub_pkg::SUM_W-1:0]    sum;
    logic [maub_pkg::WIDE_W-1:0]   n_quot;
    logic [maub_pkg::WIDE_W-1:0]   diff;
    logic [maub_pkg::WIDE_W-1:0]   corr;
    logic [maub_pkg::RES_W-1:0]    n_residue;

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v4;
    assign o_residue = r_residue;

    assign sum = {{maub_pkg::MU_HALF_W{1'b0}}, r_pp_lo}
               + {r_pp_hi, {maub_pkg::MU_HALF_W{1'b0}}};
    assign n_quot = sum[REDUCE_SHIFT +: maub_pkg::WIDE_W];
    assign diff = r_d3.wide_val - r_qp;
    assign corr = (diff >= P32) ? diff - P32 : diff;
    assign n_residue = r_d3.use_barrett ? corr[maub_pkg::RES_W-1:0] : r_d3.simple_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_d1    <= i_data;
            r_pp_lo <= i_data.wide_val * MU_LO;
            r_pp_hi <= i_data.wide_val * MU_HI;
        end
        if (en2 && r_v1) begin
            r_d2   <= r_d1;
            r_quot <= n_quot;
        end
        if (en3 && r_v2) begin
            r_d3 <= r_d2;
            r_qp <= maub_pkg::WIDE_W'(r_quot * P16);
        end
        if (en4 && r_v3) begin
            r_residue <= n_residue;
        end
    end

endmodule

### hw/rtl/modular_arith_unit_barrett_top.sv
// Top level of the Barrett modular arithmetic unit.
// Depends on maub_pkg, maub_front and maub_barrett.
//
// The unit takes one item per cycle while the output is not stalled and returns one residue
// per item, in order. The pipeline holds the front stage with the 16x16 product and the short
// operations, two stages for the quotient estimate (the constant multiply split into two
// 32x24 partial products, then their sum and shift), one stage for the quotient times the
// modulus, and the output stage with the final conditional subtraction. Every stage holds
// its item under backpressure and fills bubbles, so a stall on the output loses nothing.
module modular_arith_unit_barrett_top #(
    parameter int MODULUS      = 65521,
    parameter int REDUCE_SHIFT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // operand_a [31:0], operand_b [47:32]
    input  logic [2:0]  s_axis_tuser,   // req_type [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // residue [15:0]
);

    logic             front_valid;
    logic             front_ready;
    maub_pkg::t_front front_data;

    maub_front #(
        .MODULUS (MODULUS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_req_type  (s_axis_tuser),
        .i_operand_a (s_axis_tdata[31:0]),
        .i_operand_b (s_axis_tdata[47:32]),
        .o_valid     (front_valid),
        .i_ready     (front_ready),
        .o_data      (front_data)
    );

    maub_barrett #(
        .MODULUS      (MODULUS),
        .REDUCE_SHIFT (REDUCE_SHIFT)
    ) u_barrett (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (front_valid),
        .o_ready   (front_ready),
        .i_data    (front_data),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_residue (m_axis_tdata)
    );

endmodule

### verif/modular_arith_unit_barrett_top_tb.sv
// Self-checking testbench for modular_arith_unit_barrett_top: random and corner-case items
// with idling and backpressure on both stream ports, each residue checked in order.
// Depends on maub_pkg and the RTL of the unit; needs no files or arguments.
module modular_arith_unit_barrett_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MOD            = 65521;
    localparam int          SHIFT          = 32;
    localparam logic [63:0] MU             = (64'd1 << SHIFT) / MOD;
    localparam logic [2:0]  REQ_UNUSED_LO  = 3'd6;
    localparam logic [2:0]  REQ_UNUSED_HI  = 3'd7;
    localparam int          SETTLE_CYCLES  = 10;
    localparam int          RX_HOLD_CYCLES = 300;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          MAX_REPORTS    = 10;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] a;
        logic [15:0] b;
        logic [15:0] residue;
    } t_expected;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;    // operand_a [31:0], operand_b [47:32]
    logic [2:0]  s_axis_tuser  = '0;    // req_type [2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // residue [15:0]

    t_expected   residue_q[$];
    int          fail_count    = 0;
    int          idle_cycles   = 0;
    bit          tx_steady     = 1'b0;
    bit          rx_steady     = 1'b0;
    int          rx_hold_reqs  = 0;
    int          rx_hold_done  = 0;

    modular_arith_unit_barrett_top #(
        .MODULUS      (MOD),
        .REDUCE_SHIFT (SHIFT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [15:0] barrett_fold(logic [31:0] x);
        logic [127:0] quot;
        logic [127:0] rem;
        quot = ({96'd0, x} * {64'd0, MU}) >> SHIFT;
        rem  = {96'd0, x} - quot * MOD;
        if (rem >= MOD) begin
            rem = rem - MOD;
        end
        return rem[15:0];
    endfunction

    function automatic logic [15:0] expected_residue(logic [2:0] op, logic [31:0] a,
                                                     logic [15:0] b);
        logic [31:0] a16;
        logic [31:0] b16;
        logic [31:0] tmp;
        a16 = {16'd0, a[15:0]};
        b16 = {16'd0, b};
        case (op)
            maub_pkg::REQ_ADD: begin
                tmp = a16 + b16;
                if (tmp >= MOD) begin
                    tmp = tmp - MOD;
                end
            end
            maub_pkg::REQ_SUB: begin
                tmp = (a16 >= b16) ? a16 - b16 : a16 - b16 + MOD;
            end
            maub_pkg::REQ_MUL: begin
                tmp = {16'd0, barrett_fold(a16 * b16)};
            end
            maub_pkg::REQ_REDUCE: begin
                tmp = {16'd0, barrett_fold(a)};
            end
            maub_pkg::REQ_LEE: begin
                tmp = (MOD - a16) & 32'h0000_FFFF;
                if (tmp > a16) begin
                    tmp = a16;
                end
            end
            maub_pkg::REQ_SIGNED: begin
                tmp = a[31] ? a + MOD : a;
            end
            default: begin
                tmp = '0;
            end
        endcase
        return tmp[15:0];
    endfunction

    function automatic logic [15:0] pick_residue();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'(MOD - 1);
            default: return 16'($urandom_range(MOD - 1));
        endcase
    endfunction

    task automatic note_failure(string what, t_expected exp, logic [15:0] actual);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s op=%0d a=%h b=%h expected=%h actual=%h", $realtime, what,
                     exp.op, exp.a, exp.b, exp.residue, actual);
        end
    endtask

    always @(posedge i_clk) begin
        t_expected exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (residue_q.size() == 0) begin
                exp = '0;
                note_failure("unexpected residue", exp, m_axis_tdata);
            end else begin
                exp = residue_q.pop_front();
                if (m_axis_tdata !== exp.residue) begin
                    note_failure("residue mismatch", exp, m_axis_tdata);
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            exp.op      = s_axis_tuser;
            exp.a       = s_axis_tdata[31:0];
            exp.b       = s_axis_tdata[47:32];
            exp.residue = expected_residue(exp.op, exp.a, exp.b);
            residue_q.push_back(exp);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (rx_hold_reqs != rx_hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_done++;
            end else if (rx_steady) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 35);
            end
        end
    end

    task automatic send_item(logic [2:0] op, logic [31:0] a, logic [15:0] b);
        if (!tx_steady && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {b, a};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    task automatic send_random_item();
        logic [2:0]  op;
        logic [31:0] a;
        logic [15:0] b;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 4) begin
            op = pick[0] ? REQ_UNUSED_HI : REQ_UNUSED_LO;
        end else begin
            op = 3'($urandom_range(maub_pkg::REQ_SIGNED));
        end
        a = {16'd0, pick_residue()};
        b = pick_residue();
        case (op)
            maub_pkg::REQ_REDUCE: a = $urandom();
            maub_pkg::REQ_SIGNED:
                a = $urandom_range(1) ? 32'(0 - $urandom_range(1, MOD)) : $urandom();
            default: ;
        endcase
        if ($urandom_range(99) < 15) begin
            a = $urandom();
            b = 16'($urandom());
        end
        send_item(op, a, b);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (residue_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_directed_corners();
        send_item(maub_pkg::REQ_ADD, 32'(MOD - 1), 16'(MOD - 1));
        send_item(maub_pkg::REQ_ADD, 32'd0, 16'd0);
        send_item(maub_pkg::REQ_ADD, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(maub_pkg::REQ_SUB, 32'd0, 16'(MOD - 1));
        send_item(maub_pkg::REQ_SUB, 32'(MOD - 1), 16'd0);
        send_item(maub_pkg::REQ_SUB, 32'h0000_FFFF, 16'hFFFF);
        send_item(maub_pkg::REQ_MUL, 32'(MOD - 1), 16'(MOD - 1));
        send_item(maub_pkg::REQ_MUL, 32'd0, 16'hABCD);
        send_item(maub_pkg::REQ_MUL, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(maub_pkg::REQ_REDUCE, 32'd0, 16'd0);
        send_item(maub_pkg::REQ_REDUCE, 32'(MOD), 16'd0);
        send_item(maub_pkg::REQ_REDUCE, 32'h7FFF_FFFF, 16'd0);
        send_item(maub_pkg::REQ_REDUCE, 32'h8000_0000, 16'd0);
        send_item(maub_pkg::REQ_REDUCE, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(maub_pkg::REQ_LEE, 32'd0, 16'd0);
        send_item(maub_pkg::REQ_LEE, 32'((MOD - 1) / 2), 16'd0);
        send_item(maub_pkg::REQ_LEE, 32'((MOD + 1) / 2), 16'd0);
        send_item(maub_pkg::REQ_LEE, 32'h0000_FFFF, 16'd0);
        send_item(maub_pkg::REQ_SIGNED, 32'hFFFF_FFFF, 16'd0);
        send_item(maub_pkg::REQ_SIGNED, 32'(-MOD), 16'd0);
        send_item(maub_pkg::REQ_SIGNED, 32'h8000_0000, 16'd0);
        send_item(maub_pkg::REQ_SIGNED, 32'h7FFF_FFFF, 16'd0);
        send_item(REQ_UNUSED_LO, 32'h1234_5678, 16'h9ABC);
        send_item(REQ_UNUSED_HI, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    task automatic check_full_rate();
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        repeat (150) send_random_item();
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
    endtask

    task automatic check_output_backpressure();
        tx_steady = 1'b1;
        rx_hold_reqs <= rx_hold_reqs + 1;
        repeat (80) send_random_item();
        tx_steady = 1'b0;
    endtask

    task automatic check_drain_pause();
        repeat (60) send_random_item();
        drain_results();
        repeat (60) send_random_item();
    endtask

    task automatic check_random_mix();
        repeat (1550) send_random_item();
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_directed_corners();
        check_full_rate();
        check_output_backpressure();
        check_drain_pause();
        check_random_mix();
        drain_results();
        if (residue_q.size() != 0) begin
            fail_count += residue_q.size();
            $display("%0d expected residues never arrived", residue_q.size());
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/maub_pkg.sv
hw/rtl/maub_front.sv
hw/rtl/maub_barrett.sv
hw/rtl/modular_arith_unit_barrett_top.sv
verif/modular_arith_unit_barrett_top_tb.sv
